// ----- sv/dsch_pkg.sv -----
package dsch_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	typedef enum logic [2:0] {
		FN_REQUEST = 3'd0,
		FN_FCFS    = 3'd1,
		FN_SSTF    = 3'd2,
		FN_LOOK    = 3'd3,
		FN_CLOOK   = 3'd4
	} func_t;

	localparam logic CFG_TRACK_COUNT = 1'b0;
	localparam logic CFG_START_HEAD  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_REQ_RD,
		ST_REQ_WR,
		ST_FIFO_RD,
		ST_FIFO_MAP,
		ST_FIFO_CHK,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_SRV_RD,
		ST_SRV_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	// index of highest set bit
	function automatic logic [BIT_W-1:0] msb_idx(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	// index of lowest set bit
	function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

endpackage

// ----- sv/dsch_map_ram.sv -----
module dsch_map_ram import dsch_pkg::*; #(
	parameter int WORDS = 2048,
	parameter int AW    = 11
) (
	input  logic              clk,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata
);

	logic [WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

// ----- sv/dsch_fifo.sv -----
module dsch_fifo import dsch_pkg::*; #(
	parameter int DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fifo_ctl_t   ctl,
	input  logic [15:0] wdata,
	output logic [15:0] rdata,
	output logic        empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [15:0]   mem [DEPTH];
	logic [PW-1:0] rd_q, wr_q;
	logic [FW-1:0] fill_q;
	logic          full;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (fill_q == FW'(DEPTH));
	assign empty = (fill_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			wr_q <= inc(wr_q);
			// full: drop the oldest entry
			if (full) rd_q <= inc(rd_q);
			else fill_q <= fill_q + 1'b1;
		end else if (ctl.pop) begin
			rd_q   <= inc(rd_q);
			fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) rdata <= mem[rd_q];
	end

endmodule

// ----- sv/disk_request_scheduler.sv -----
// Disk request scheduler.
// Input channel (in_valid/in_stall, func, track): func REQUEST marks a track
// pending and queues it; FCFS, SSTF, LOOK and C-LOOK serve one pending track.
// Output channel (out_valid/out_stall, served_track, none_pending): one
// transaction per service item; none_pending=1 with served_track=0 when
// nothing can be served. Requests and unknown func codes give no output.
// Pending tracks live in a bitmap RAM of TRACKS/32 words; the arrival queue
// is a RAM of FIFO_DEPTH entries. Each search scans one bitmap word at a
// time, reading it and then masking and priority encoding it, and covers up
// to TRACKS/32 words per pass; SSTF always makes a second pass, as do a
// LOOK reversal and a C-LOOK wrap. FCFS skips stale and out-of-range queue
// entries. One item is in work at a time; in_stall is high until it
// finishes. A finished result sits in the output register, so the next
// item is accepted while out_stall holds it; a second result waits.
// Reset: head at 0, sweep toward track 0, queue empty, and a clearing pass
// zeroes the bitmap with in_stall high. Config writes
// (cfg_we/cfg_index/cfg_data) are taken at any time, meant for idle periods.
module disk_request_scheduler import dsch_pkg::*; #(
	parameter int TRACKS     = 65536,
	parameter int FIFO_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] track,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] served_track,
	output logic        none_pending,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int WORDS = (TRACKS + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int EW    = ($clog2(TRACKS) > 17) ? $clog2(TRACKS) : 17;

	state_t state_q, state_d;

	// configuration and scheduler state
	logic [16:0]   track_count_q;
	logic [15:0]   head_q;
	logic          sweep_down_q;

	// item registers
	logic [2:0]    func_q;
	logic [15:0]   trk_q;
	logic          phase_q;
	logic [AW-1:0] clr_q;

	// scan unit
	logic [AW-1:0]    scan_addr_q;
	logic [BIT_W-1:0] scan_bit_q;
	logic             scan_down_q, scan_first_q, scan_empty_q;
	logic             dn_hit_q;
	logic [EW-1:0]    dn_trk_q, srv_q;

	// result and output registers
	logic          res_fail_q;
	logic [15:0]   res_trk_q;
	logic          out_valid_q, none_pending_q;
	logic [15:0]   served_track_q;

	// effective last track
	logic [EW:0]      tc_x;
	logic [EW-1:0]    eff_last;
	logic [AW-1:0]    eff_word;
	logic [BIT_W-1:0] eff_bit;

	// memories
	logic              map_re, map_we;
	logic [AW-1:0]     map_raddr, map_waddr;
	logic [WORD_W-1:0] map_rdata, map_wdata;
	fifo_ctl_t         fctl;
	logic [15:0]       fifo_rdata;
	logic              fifo_empty;

	// control from the sequencer
	logic          accept, out_load;
	logic          scan_go, scan_go_down, scan_step;
	logic [EW-1:0] scan_go_from, st_from;
	logic          phase_set, phase_val;
	logic          dn_save, srv_load, res_set, res_fail, flip;
	logic [EW-1:0] srv_val;

	// scan evaluation
	logic [WORD_W-1:0] wmask, fmask, cand;
	logic              hit, last;
	logic [BIT_W-1:0]  enc;
	logic [EW-1:0]     hit_trk, head_x, trk_x, fifo_x;

	assign tc_x = (EW+1)'(track_count_q);
	always_comb begin
		if (track_count_q == '0) eff_last = '0;
		else if (tc_x > (EW+1)'(TRACKS)) eff_last = EW'(TRACKS - 1);
		else eff_last = EW'(tc_x - 1'b1);
	end
	assign eff_word = eff_last[AW+BIT_W-1:BIT_W];
	assign eff_bit  = eff_last[BIT_W-1:0];

	assign head_x = EW'(head_q);
	assign trk_x  = EW'(trk_q);
	assign fifo_x = EW'(fifo_rdata);

	dsch_map_ram #(.WORDS(WORDS), .AW(AW)) u_map (
		.clk   (clk),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata)
	);

	dsch_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.wdata  (trk_q),
		.rdata  (fifo_rdata),
		.empty  (fifo_empty)
	);

	// Word masks: bits past the last track in range, and the start bit
	// limit on the first word of a scan.
	always_comb begin
		if (scan_addr_q < eff_word) wmask = '1;
		else if (scan_addr_q == eff_word) wmask = {WORD_W{1'b1}} >> (5'd31 - eff_bit);
		else wmask = '0;
		if (!scan_first_q) fmask = '1;
		else if (scan_down_q) fmask = {WORD_W{1'b1}} >> (5'd31 - scan_bit_q);
		else fmask = {WORD_W{1'b1}} << scan_bit_q;
		cand    = map_rdata & wmask & fmask;
		hit     = (|cand) && !scan_empty_q;
		enc     = scan_down_q ? msb_idx(cand) : lsb_idx(cand);
		hit_trk = EW'({scan_addr_q, enc});
		last    = scan_empty_q || (scan_down_q ? (scan_addr_q == '0)
		                                       : (scan_addr_q == eff_word));
	end

	// downward scans start no higher than the last track in range
	assign st_from = (scan_go_down && scan_go_from > eff_last) ? eff_last : scan_go_from;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		map_re       = 1'b0;
		map_raddr    = '0;
		map_we       = 1'b0;
		map_waddr    = '0;
		map_wdata    = '0;
		fctl         = '0;
		scan_go      = 1'b0;
		scan_go_down = 1'b1;
		scan_go_from = head_x;
		scan_step    = 1'b0;
		phase_set    = 1'b0;
		phase_val    = 1'b0;
		dn_save      = 1'b0;
		srv_load     = 1'b0;
		srv_val      = hit_trk;
		res_set      = 1'b0;
		res_fail     = 1'b0;
		flip         = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				if (clr_q == AW'(WORDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					phase_set = 1'b1;
					case (func) inside
						FN_REQUEST: begin
							if (EW'(track) <= eff_last) state_d = ST_REQ_RD;
						end
						FN_FCFS: state_d = ST_FIFO_RD;
						FN_SSTF, FN_CLOOK: begin
							scan_go = 1'b1;
							state_d = ST_SCAN_RD;
						end
						FN_LOOK: begin
							scan_go      = 1'b1;
							scan_go_down = sweep_down_q;
							state_d      = ST_SCAN_RD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_REQ_RD: begin
				map_re    = 1'b1;
				map_raddr = trk_x[AW+BIT_W-1:BIT_W];
				fctl.push = 1'b1;
				state_d   = ST_REQ_WR;
			end
			ST_REQ_WR: begin
				map_we    = 1'b1;
				map_waddr = trk_x[AW+BIT_W-1:BIT_W];
				map_wdata = map_rdata | (WORD_W'(1) << trk_q[BIT_W-1:0]);
				state_d   = ST_IDLE;
			end
			ST_FIFO_RD: begin
				if (fifo_empty) begin
					// queue drained: lowest pending track
					scan_go      = 1'b1;
					scan_go_down = 1'b0;
					scan_go_from = '0;
					state_d      = ST_SCAN_RD;
				end else begin
					fctl.pop = 1'b1;
					state_d  = ST_FIFO_MAP;
				end
			end
			ST_FIFO_MAP: begin
				if (fifo_x > eff_last) begin
					state_d = ST_FIFO_RD;
				end else begin
					map_re    = 1'b1;
					map_raddr = fifo_x[AW+BIT_W-1:BIT_W];
					srv_load  = 1'b1;
					srv_val   = fifo_x;
					state_d   = ST_FIFO_CHK;
				end
			end
			ST_FIFO_CHK: begin
				// map_rdata already holds the entry's word
				if (map_rdata[srv_q[BIT_W-1:0]]) state_d = ST_SRV_WR;
				else state_d = ST_FIFO_RD;
			end
			ST_SCAN_RD: begin
				map_re    = 1'b1;
				map_raddr = scan_addr_q;
				state_d   = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				if (!hit && !last) begin
					scan_step = 1'b1;
					state_d   = ST_SCAN_RD;
				end else begin
					case (func_q) inside
						FN_SSTF: begin
							if (!phase_q) begin
								dn_save      = 1'b1;
								scan_go      = 1'b1;
								scan_go_down = 1'b0;
								phase_set    = 1'b1;
								phase_val    = 1'b1;
								state_d      = ST_SCAN_RD;
							end else if (dn_hit_q && (!hit ||
							             (head_x - dn_trk_q) <= (hit_trk - head_x))) begin
								srv_load = 1'b1;
								srv_val  = dn_trk_q;
								state_d  = ST_SRV_RD;
							end else if (hit) begin
								srv_load = 1'b1;
								state_d  = ST_SRV_RD;
							end else begin
								res_set  = 1'b1;
								res_fail = 1'b1;
								state_d  = ST_DONE;
							end
						end
						FN_LOOK, FN_CLOOK: begin
							if (hit) begin
								srv_load = 1'b1;
								flip     = phase_q && (func_q == FN_LOOK);
								state_d  = ST_SRV_RD;
							end else if (!phase_q) begin
								scan_go   = 1'b1;
								phase_set = 1'b1;
								phase_val = 1'b1;
								state_d   = ST_SCAN_RD;
								if (func_q == FN_LOOK) begin
									scan_go_down = !sweep_down_q;
								end else begin
									// C-LOOK wraps to the top track
									scan_go_from = eff_last;
								end
							end else begin
								res_set  = 1'b1;
								res_fail = 1'b1;
								state_d  = ST_DONE;
							end
						end
						default: begin
							if (hit) begin
								srv_load = 1'b1;
								state_d  = ST_SRV_RD;
							end else begin
								res_set  = 1'b1;
								res_fail = 1'b1;
								state_d  = ST_DONE;
							end
						end
					endcase
				end
			end
			ST_SRV_RD: begin
				map_re    = 1'b1;
				map_raddr = srv_q[AW+BIT_W-1:BIT_W];
				state_d   = ST_SRV_WR;
			end
			ST_SRV_WR: begin
				map_we    = 1'b1;
				map_waddr = srv_q[AW+BIT_W-1:BIT_W];
				map_wdata = map_rdata & ~(WORD_W'(1) << srv_q[BIT_W-1:0]);
				res_set   = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= 17'h10000;
			head_q        <= '0;
			sweep_down_q  <= 1'b1;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_TRACK_COUNT) track_count_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_START_HEAD) head_q <= cfg_data[15:0];
			else if (state_q == ST_SRV_WR) head_q <= srv_q[15:0];
			if (flip) sweep_down_q <= !sweep_down_q;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			trk_q  <= track;
		end
		if (phase_set) phase_q <= phase_val;
		if (scan_go) begin
			scan_addr_q  <= st_from[AW+BIT_W-1:BIT_W];
			scan_bit_q   <= st_from[BIT_W-1:0];
			scan_down_q  <= scan_go_down;
			scan_first_q <= 1'b1;
			scan_empty_q <= !scan_go_down && (scan_go_from > eff_last);
		end else if (scan_step) begin
			scan_addr_q  <= scan_down_q ? scan_addr_q - 1'b1 : scan_addr_q + 1'b1;
			scan_first_q <= 1'b0;
		end
		if (dn_save) begin
			dn_hit_q <= hit;
			dn_trk_q <= hit_trk;
		end
		if (srv_load) srv_q <= srv_val;
		if (res_set) begin
			res_fail_q <= res_fail;
			res_trk_q  <= res_fail ? 16'd0 : srv_q[15:0];
		end
		if (out_load) begin
			served_track_q <= res_trk_q;
			none_pending_q <= res_fail_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign served_track = served_track_q;
	assign none_pending = none_pending_q;

`ifndef ASSERT_OFF
	a_no_map_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !map_we)
		else $error("bitmap written while idle");

	a_error_zero_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && none_pending) |-> (served_track == 16'd0))
		else $error("error result carries a track");

	a_fifo_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(fctl.push && fctl.pop))
		else $error("queue push and pop together");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_EV && !scan_empty_q) |-> (scan_addr_q <= eff_word))
		else $error("scan beyond last word");
`endif

endmodule
